FILE: rtl/core/ltdd_pkg.sv
// Package for the lock table deadlock detector: request/response words,
// mode codes and size constants. No dependencies.
`default_nettype none
package ltdd_pkg;
   localparam int NUM_PROCS_DEF   = 64;
   localparam int NUM_LOCKS_DEF   = 64;
   localparam int ENERGY_BITS_DEF = 32;

   localparam logic [1:0] MODE_ACQUIRE = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_SET     = 2'd2;
   localparam logic [1:0] MODE_QUERY   = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  proc_id;
      logic [5:0]  lock_id;
      logic        proc_active;
      logic [31:0] energy;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic       deadlock_found;
      logic       victim_found;
      logic [5:0] victim_id;
      logic       holding;
   } rsp_type;
endpackage
`default_nettype wire

FILE: rtl/core/lock_table_deadlock_detector.sv
// Lock table deadlock detector top level: tables, walk sequencer, output register.
// Depends on ltdd_pkg.
//
// req_stall is high while a request word is in progress. Acquire of a free
// lock, release, set and query are accepted, decided in S_DECIDE and loaded
// into the response register from S_DONE. Every table read is registered, so
// a blocked acquire walks the owner chain in S_DETECT and S_DET_NEXT per hop
// through a single shared hop unit (one wait-lock read, one owner read and one
// energy compare). A walk that finds no cycle stops at a dead end or after
// NUM_PROCS hops; a walk that closes a cycle is followed by a second walk for
// the victim. The response register holds until taken, and a finished word
// waits in the last state while an older response is still stalled.
`default_nettype none
module lock_table_deadlock_detector #(
   parameter int NUM_PROCS   = ltdd_pkg::NUM_PROCS_DEF,
   parameter int NUM_LOCKS   = ltdd_pkg::NUM_LOCKS_DEF,
   parameter int ENERGY_BITS = ltdd_pkg::ENERGY_BITS_DEF
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   input  ltdd_pkg::req_type req_word,
   output logic            rsp_valid,
   input  wire             rsp_stall,
   output ltdd_pkg::rsp_type rsp_word
);
   import ltdd_pkg::*;

   localparam int PW = $clog2(NUM_PROCS);
   localparam int LW = $clog2(NUM_LOCKS);
   localparam int HW = $clog2(NUM_PROCS + 1);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECIDE   = 7'b0000010,
      S_DETECT   = 7'b0000100,
      S_DET_NEXT = 7'b0001000,
      S_VIC_NEXT = 7'b0010000,
      S_VICTIM   = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [NUM_LOCKS-1:0] held_ff, held_in;
   logic [NUM_PROCS-1:0] valid_ff, valid_in, wait_ff, wait_in, kill_ff, kill_in;
   logic [5:0]       owner_mem [NUM_LOCKS];
   logic [5:0]       wlock_mem [NUM_PROCS];
   logic [ENERGY_BITS-1:0] en_raw [NUM_PROCS];
   logic [NUM_PROCS-1:0] en_set_ff;
   logic [5:0]       owner_rd_ff, wlock_rd_ff;
   logic [ENERGY_BITS-1:0] energy_rd_ff;
   logic             en_set_rd_ff;
   logic [5:0]       cur_ff, cur_in, victim_ff, victim_in;
   logic [ENERGY_BITS-1:0] best_ff, best_in;
   logic [HW-1:0]    hops_ff, hops_in;
   logic             nxt_ok_ff, nxt_ok_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             pid_ok, lk_ok, cur_live, nxt_ok;
   logic [PW-1:0]    pid_ix, cur_ix, cur_raddr;
   logic [LW-1:0]    lk_ix, wl_ix, own_raddr;
   logic [ENERGY_BITS-1:0] cur_energy;
   logic             own_wr, wl_wr, en_wr;

   assign pid_ix   = PW'(req_ff.proc_id);
   assign lk_ix    = LW'(req_ff.lock_id);
   assign pid_ok   = (req_ff.proc_id != 6'd0) && (32'(req_ff.proc_id) < NUM_PROCS);
   assign lk_ok    = 32'(req_ff.lock_id) < NUM_LOCKS;
   assign cur_ix   = PW'(cur_ff);
   assign cur_live = (cur_ff != 6'd0) && (32'(cur_ff) < NUM_PROCS) && valid_ff[cur_ix];
   assign wl_ix    = LW'(wlock_rd_ff);
   // next hop: owner of the held lock cur waits on, else stop
   assign nxt_ok   = wait_ff[cur_ix] && (32'(wlock_rd_ff) < NUM_LOCKS) && held_ff[wl_ix];
   assign cur_energy = en_set_rd_ff ? energy_rd_ff : '0;
   assign cur_raddr  = PW'(cur_in);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      state_in = state_ff; req_in = req_ff; held_in = held_ff; valid_in = valid_ff;
      wait_in = wait_ff; kill_in = kill_ff; cur_in = cur_ff; victim_in = victim_ff;
      best_in = best_ff; hops_in = hops_ff; nxt_ok_in = nxt_ok_ff;
      res_in = res_ff; rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      own_wr = 1'b0; wl_wr = 1'b0; en_wr = 1'b0;
      own_raddr = lk_ix;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            own_raddr = LW'(req_word.lock_id);
            if (req_valid) begin
               req_in = req_word;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_in = '0;
            state_in = S_DONE;
            case (req_ff.mode)
               MODE_ACQUIRE: begin
                  if (pid_ok && lk_ok) begin
                     if (!held_ff[lk_ix]) begin
                        held_in[lk_ix] = 1'b1;
                        own_wr = 1'b1;
                        wait_in[pid_ix] = 1'b0;
                        res_in.granted = 1'b1;
                     end else begin
                        wait_in[pid_ix] = 1'b1;
                        wl_wr = 1'b1;
                        cur_in = owner_rd_ff;
                        hops_in = '0;
                        state_in = S_DETECT;
                     end
                  end
               end
               MODE_RELEASE: begin
                  if (lk_ok) begin
                     held_in[lk_ix] = 1'b0;
                     own_wr = 1'b1;
                  end
               end
               MODE_SET: begin
                  if (pid_ok) begin
                     valid_in[pid_ix] = req_ff.proc_active;
                     en_wr = 1'b1;
                  end
               end
               MODE_QUERY: begin
                  res_in.holding = lk_ok && held_ff[lk_ix] && (owner_rd_ff == req_ff.proc_id);
               end
               default: ;
            endcase
         end
         S_DETECT: begin
            if (32'(hops_ff) >= NUM_PROCS || !cur_live) begin
               state_in = S_DONE;
            end else if (cur_ff == req_ff.proc_id) begin
               // cycle closed: seed the victim walk with the requester, refetch the owner
               res_in.deadlock_found = 1'b1;
               best_in   = cur_energy;
               victim_in = (cur_energy != '0) ? req_ff.proc_id : 6'd0;
               own_raddr = lk_ix;
               nxt_ok_in = 1'b1;
               hops_in   = '0;
               state_in  = S_VIC_NEXT;
            end else begin
               own_raddr = wl_ix;
               nxt_ok_in = nxt_ok;
               hops_in   = hops_ff + HW'(1);
               state_in  = S_DET_NEXT;
            end
         end
         S_DET_NEXT: begin
            cur_in   = nxt_ok_ff ? owner_rd_ff : 6'd0;
            state_in = S_DETECT;
         end
         S_VIC_NEXT: begin
            cur_in   = nxt_ok_ff ? owner_rd_ff : 6'd0;
            state_in = S_VICTIM;
         end
         S_VICTIM: begin
            if (cur_ff == req_ff.proc_id || 32'(hops_ff) >= NUM_PROCS || !cur_live) begin
               if (victim_ff != 6'd0) begin
                  kill_in[PW'(victim_ff)] = 1'b1;
                  res_in.victim_found = 1'b1;
                  res_in.victim_id = victim_ff;
               end
               state_in = S_DONE;
            end else begin
               if (cur_energy > best_ff) begin
                  best_in = cur_energy;
                  victim_in = cur_ff;
               end
               own_raddr = wl_ix;
               nxt_ok_in = nxt_ok;
               hops_in   = hops_ff + HW'(1);
               state_in  = S_VIC_NEXT;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; held_ff <= '0; valid_ff <= '0; wait_ff <= '0;
         kill_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; held_ff <= held_in; valid_ff <= valid_in;
         wait_ff <= wait_in; kill_ff <= kill_in; rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in; cur_ff <= cur_in; victim_ff <= victim_in;
      best_ff <= best_in; hops_ff <= hops_in; nxt_ok_ff <= nxt_ok_in;
      res_ff <= res_in; rsp_ff <= rsp_in;
   end

   // owner reads of unheld locks are masked by held_ff and wait-lock reads by
   // the waiting flag; energy of an unwritten entry reads as zero via en_set_ff
   always_ff @(posedge clock) begin
      if (own_wr) owner_mem[lk_ix] <= (req_ff.mode == MODE_ACQUIRE) ? req_ff.proc_id : 6'd0;
      if (wl_wr) wlock_mem[pid_ix] <= req_ff.lock_id;
      if (en_wr) en_raw[pid_ix] <= ENERGY_BITS'({32'd0, req_ff.energy});
      owner_rd_ff  <= owner_mem[own_raddr];
      wlock_rd_ff  <= wlock_mem[cur_raddr];
      energy_rd_ff <= en_raw[cur_raddr];
      en_set_rd_ff <= en_set_ff[cur_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) en_set_ff <= '0;
      else if (en_wr) en_set_ff[pid_ix] <= 1'b1;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.victim_found |-> rsp_word.deadlock_found)
      else $error("victim without deadlock");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.granted |-> !rsp_word.deadlock_found && !rsp_word.holding)
      else $error("conflicting response bits");
endmodule
`default_nettype wire
